FILE: src/drg_pkg.sv
// shared types and constants for the depth seeded region growing core
// no dependencies
`default_nettype none

package drg_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;

    localparam int CMD_W      = 2;
    localparam int COORD_X_W  = 10;
    localparam int COORD_Y_W  = 9;
    localparam int DEPTH_W    = 16;
    localparam int THR_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int MEAN_W     = DEPTH_W + FRAC_W;
    localparam int REGION_W   = 19;
    localparam logic [THR_W-1:0] THR_RESET = 16'd200;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_GROW  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [COORD_X_W-1:0] x;
        logic [COORD_Y_W-1:0] y;
        logic [DEPTH_W-1:0]   dep;
    } front_t;

endpackage

`default_nettype wire

FILE: src/drg_div.sv
// restoring divider, one quotient bit per cycle, for the region mean update
// no package dependencies; numerator high part must be below the divisor
`default_nettype none

module drg_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 19,
    parameter int Q_W   = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [Q_W-1:0]        quot
);

    localparam int CW = $clog2(Q_W + 1);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[Q_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= DEN_W'(num[NUM_W-1:Q_W]);
                q_reg    <= num[Q_W-1:0];
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                q_reg   <= {q_reg[Q_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

FILE: src/depth_seeded_region_growing_core.sv
// top level: depth image store and 4-connected seeded region growing
// depends on drg_pkg and drg_div
//
// The block holds a depth image, a per-seed visit map, a union mask and a
// frontier list in synchronous memories with one read and one write port.
// After reset it sweeps the union mask to zero, one pixel a cycle, and takes
// no command meanwhile; the configuration port is always ready. A pixel write,
// a keep-bit read and a mask clear each end in one result; a mask clear sweeps
// the union mask to zero first. A grow first sweeps the visit map, then for
// every accepted pixel checks the four neighbours, scans the frontier memory
// one entry a cycle, and updates the mean in the bit-serial divider. Results
// wait in an output register while the next command is taken.
`default_nettype none

module depth_seeded_region_growing_core #(
    parameter int FRONTIER_DEPTH = 16384
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire logic [drg_pkg::CMD_W-1:0]      command,
    input  wire logic [drg_pkg::COORD_X_W-1:0]  coord_x,
    input  wire logic [drg_pkg::COORD_Y_W-1:0]  coord_y,
    input  wire logic [drg_pkg::DEPTH_W-1:0]    depth_value,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output logic                                keep_bit,
    output logic [drg_pkg::REGION_W-1:0]        region_size,
    output logic                                seed_skipped,
    output logic                                frontier_overflow,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [drg_pkg::THR_W-1:0]      grow_threshold
);

    import drg_pkg::*;

    localparam int NPIX  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int PW    = $clog2(NPIX);
    localparam int CNT_W = $clog2(NPIX + 1);
    localparam int FW    = $clog2(FRONTIER_DEPTH);
    localparam int FCW   = $clog2(FRONTIER_DEPTH + 1);
    localparam int NUM_W = MEAN_W + CNT_W + 1;

    localparam logic [COORD_X_W-1:0] X_LAST   = COORD_X_W'(IMAGE_WIDTH - 1);
    localparam logic [COORD_Y_W-1:0] Y_LAST   = COORD_Y_W'(IMAGE_HEIGHT - 1);
    localparam logic [PW-1:0]        W_P      = PW'(IMAGE_WIDTH);
    localparam logic [PW-1:0]        P_LAST   = PW'(NPIX - 1);
    localparam logic [CNT_W-1:0]     N_ALL    = CNT_W'(NPIX);
    localparam logic [FCW-1:0]       F_FULL   = FCW'(FRONTIER_DEPTH);

    localparam logic [1:0] VISIT_NONE   = 2'd0;
    localparam logic [1:0] VISIT_FRONT  = 2'd1;
    localparam logic [1:0] VISIT_REGION = 2'd2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_EXEC, S_RDW, S_SEED, S_VCLR, S_INIT, S_NB, S_NBW,
        S_SCAN, S_DECIDE, S_MOVE, S_DIV, S_DONE
    } state_t;

    state_t state_reg;

    logic [THR_W-1:0]     thr_reg;
    cmd_t                 cmd_reg;
    logic [COORD_X_W-1:0] x_reg;
    logic [COORD_Y_W-1:0] y_reg;
    logic [DEPTH_W-1:0]   dv_reg;
    logic                 pend_res_reg;
    logic [PW-1:0]        sweep_reg;
    logic [PW-1:0]        p_reg;
    logic [PW-1:0]        cur_p_reg;
    logic [COORD_X_W-1:0] cx_reg;
    logic [COORD_Y_W-1:0] cy_reg;
    logic [1:0]           nb_reg;
    logic [PW-1:0]        np_reg;
    logic [COORD_X_W-1:0] nx_reg;
    logic [COORD_Y_W-1:0] ny_reg;
    logic [FCW-1:0]       fcount_reg;
    logic [FCW-1:0]       idx_reg;
    logic                 rdv_reg;
    logic [FW-1:0]        ridx_reg;
    logic [MEAN_W-1:0]    bestd_reg;
    logic [FW-1:0]        best_idx_reg;
    front_t               best_reg;
    logic [PW-1:0]        bp_reg;
    logic [MEAN_W+CNT_W-1:0] prod_reg;
    logic [MEAN_W-1:0]    mean_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic                 pk_reg;
    logic [REGION_W-1:0]  psz_reg;
    logic                 pskip_reg;
    logic                 res_valid_reg;
    logic                 keep_reg;
    logic [REGION_W-1:0]  size_reg;
    logic                 skip_reg;
    logic                 rovf_reg;

    logic [DEPTH_W-1:0]   depth_mem [NPIX];
    logic [1:0]           visit_mem [NPIX];
    logic                 union_mem [NPIX];
    front_t               front_mem [FRONTIER_DEPTH];

    logic [DEPTH_W-1:0]   dep_q;
    logic [1:0]           vis_q;
    logic                 uni_q;
    front_t               front_q;

    logic                 in_img;
    logic [PW-1:0]        p_calc;
    logic                 nb_ok;
    logic [PW-1:0]        nb_p;
    logic [COORD_X_W-1:0] nb_x;
    logic [COORD_Y_W-1:0] nb_y;
    logic [PW-1:0]        dep_raddr;
    logic                 dep_we;
    logic                 vis_we;
    logic [PW-1:0]        vis_waddr;
    logic [1:0]           vis_wdata;
    logic                 uni_we;
    logic [PW-1:0]        uni_waddr;
    logic                 uni_wdata;
    logic [FW-1:0]        fr_raddr;
    logic                 fr_we;
    logic [FW-1:0]        fr_waddr;
    front_t               fr_wdata;
    logic                 nb_add;
    logic [MEAN_W-1:0]    scan_d;
    logic [MEAN_W-1:0]    scan_v;
    logic                 out_free;
    logic                 div_start;
    logic [NUM_W-1:0]     div_num;
    logic [CNT_W-1:0]     div_den;
    logic                 div_done;
    logic [MEAN_W-1:0]    div_quot;
    logic [CNT_W-1:0]     count_inc;

    drg_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W),
        .Q_W   (MEAN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        in_img = (32'(x_reg) < 32'(IMAGE_WIDTH)) && (32'(y_reg) < 32'(IMAGE_HEIGHT));
        p_calc = PW'(32'(y_reg) * 32'(IMAGE_WIDTH) + 32'(x_reg));
        case (nb_reg)
            2'd0:
            begin
                nb_ok = cx_reg != '0;
                nb_p  = cur_p_reg - 1'b1;
                nb_x  = cx_reg - 1'b1;
                nb_y  = cy_reg;
            end
            2'd1:
            begin
                nb_ok = cx_reg != X_LAST;
                nb_p  = cur_p_reg + 1'b1;
                nb_x  = cx_reg + 1'b1;
                nb_y  = cy_reg;
            end
            2'd2:
            begin
                nb_ok = cy_reg != '0;
                nb_p  = cur_p_reg - W_P;
                nb_x  = cx_reg;
                nb_y  = cy_reg - 1'b1;
            end
            default:
            begin
                nb_ok = cy_reg != Y_LAST;
                nb_p  = cur_p_reg + W_P;
                nb_x  = cx_reg;
                nb_y  = cy_reg + 1'b1;
            end
        endcase

        nb_add    = (vis_q == VISIT_NONE) && (fcount_reg < F_FULL);
        dep_raddr = (state_reg == S_NB) ? nb_p : p_calc;
        dep_we    = (state_reg == S_EXEC) && (cmd_reg == CMD_WRITE) && in_img;

        vis_we    = 1'b0;
        vis_waddr = sweep_reg;
        vis_wdata = VISIT_NONE;
        uni_we    = 1'b0;
        uni_waddr = sweep_reg;
        uni_wdata = 1'b0;
        fr_we     = 1'b0;
        fr_waddr  = fcount_reg[FW-1:0];
        fr_wdata  = '{x: nx_reg, y: ny_reg, dep: dep_q};
        fr_raddr  = idx_reg[FW-1:0];
        div_start = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                uni_we = 1'b1;
            end
            S_VCLR:
            begin
                vis_we = 1'b1;
            end
            S_INIT:
            begin
                vis_we    = 1'b1;
                vis_waddr = p_reg;
                vis_wdata = VISIT_REGION;
                uni_we    = 1'b1;
                uni_waddr = p_reg;
                uni_wdata = 1'b1;
            end
            S_NBW:
            begin
                vis_we    = nb_add;
                vis_waddr = np_reg;
                vis_wdata = VISIT_FRONT;
                uni_we    = nb_add;
                uni_waddr = np_reg;
                uni_wdata = 1'b1;
                fr_we     = nb_add;
            end
            S_DECIDE:
            begin
                fr_raddr = FW'(fcount_reg - 1'b1);
            end
            S_MOVE:
            begin
                fr_we     = 1'b1;
                fr_waddr  = best_idx_reg;
                fr_wdata  = front_q;
                vis_we    = 1'b1;
                vis_waddr = bp_reg;
                vis_wdata = VISIT_REGION;
                div_start = 1'b1;
            end
            default:
            begin
            end
        endcase

        scan_v    = {front_q.dep, {FRAC_W{1'b0}}};
        scan_d    = (scan_v > mean_reg) ? scan_v - mean_reg : mean_reg - scan_v;
        count_inc = count_reg + 1'b1;
        div_den   = count_inc;
        div_num   = NUM_W'(prod_reg) + NUM_W'({best_reg.dep, {FRAC_W{1'b0}}})
                  + NUM_W'(count_inc >> 1);
        out_free  = !res_valid_reg || !res_stall;
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            depth_mem[p_calc] <= dv_reg;
        end
        dep_q <= depth_mem[dep_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            visit_mem[vis_waddr] <= vis_wdata;
        end
        vis_q <= visit_mem[nb_p];
    end

    always_ff @(posedge clk)
    begin
        if (uni_we)
        begin
            union_mem[uni_waddr] <= uni_wdata;
        end
        uni_q <= union_mem[p_calc];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            front_mem[fr_waddr] <= fr_wdata;
        end
        front_q <= front_mem[fr_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            thr_reg       <= THR_RESET;
            cmd_reg       <= CMD_WRITE;
            x_reg         <= '0;
            y_reg         <= '0;
            dv_reg        <= '0;
            pend_res_reg  <= 1'b0;
            sweep_reg     <= '0;
            p_reg         <= '0;
            cur_p_reg     <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            nb_reg        <= '0;
            np_reg        <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            fcount_reg    <= '0;
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            ridx_reg      <= '0;
            bestd_reg     <= '0;
            best_idx_reg  <= '0;
            best_reg      <= '0;
            bp_reg        <= '0;
            prod_reg      <= '0;
            mean_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pk_reg        <= 1'b0;
            psz_reg       <= '0;
            pskip_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
            size_reg      <= '0;
            skip_reg      <= 1'b0;
            rovf_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= grow_threshold;
            end
            if (res_valid_reg && !res_stall && (state_reg != S_DONE))
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    if (sweep_reg == P_LAST)
                    begin
                        sweep_reg <= '0;
                        state_reg <= pend_res_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd_t'(command);
                        x_reg     <= coord_x;
                        y_reg     <= coord_y;
                        dv_reg    <= depth_value;
                        pk_reg    <= 1'b0;
                        psz_reg   <= '0;
                        pskip_reg <= 1'b0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    p_reg <= p_calc;
                    unique case (cmd_reg)
                        CMD_WRITE:
                        begin
                            state_reg <= S_DONE;
                        end
                        CMD_READ:
                        begin
                            state_reg <= S_RDW;
                        end
                        CMD_GROW:
                        begin
                            if (in_img)
                            begin
                                state_reg <= S_SEED;
                            end
                            else
                            begin
                                pskip_reg <= 1'b1;
                                state_reg <= S_DONE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            pend_res_reg <= 1'b1;
                            sweep_reg    <= '0;
                            state_reg    <= S_CLR;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_RDW:
                begin
                    pk_reg    <= in_img ? !uni_q : 1'b1;
                    state_reg <= S_DONE;
                end
                S_SEED:
                begin
                    if ((dep_q == '0) || uni_q)
                    begin
                        pskip_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        mean_reg  <= {dep_q, {FRAC_W{1'b0}}};
                        sweep_reg <= '0;
                        state_reg <= S_VCLR;
                    end
                end
                S_VCLR:
                begin
                    if (sweep_reg == P_LAST)
                    begin
                        sweep_reg <= '0;
                        state_reg <= S_INIT;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_INIT:
                begin
                    count_reg  <= CNT_W'(1);
                    fcount_reg <= '0;
                    cx_reg     <= x_reg;
                    cy_reg     <= y_reg;
                    cur_p_reg  <= p_reg;
                    nb_reg     <= '0;
                    state_reg  <= S_NB;
                end
                S_NB:
                begin
                    np_reg <= nb_p;
                    nx_reg <= nb_x;
                    ny_reg <= nb_y;
                    if (nb_ok)
                    begin
                        state_reg <= S_NBW;
                    end
                    else if (nb_reg == 2'd3)
                    begin
                        idx_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        state_reg <= (fcount_reg == '0) ? S_DONE : S_SCAN;
                        psz_reg   <= REGION_W'(count_reg);
                    end
                    else
                    begin
                        nb_reg <= nb_reg + 1'b1;
                    end
                end
                S_NBW:
                begin
                    if (vis_q == VISIT_NONE)
                    begin
                        if (fcount_reg < F_FULL)
                        begin
                            fcount_reg <= fcount_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    if (nb_reg == 2'd3)
                    begin
                        idx_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        psz_reg   <= REGION_W'(count_reg);
                        state_reg <= ((fcount_reg == '0) && !nb_add) ? S_DONE : S_SCAN;
                    end
                    else
                    begin
                        nb_reg    <= nb_reg + 1'b1;
                        state_reg <= S_NB;
                    end
                end
                S_SCAN:
                begin
                    rdv_reg  <= idx_reg < fcount_reg;
                    ridx_reg <= idx_reg[FW-1:0];
                    if (idx_reg < fcount_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rdv_reg && ((ridx_reg == '0) || (scan_d < bestd_reg)))
                    begin
                        bestd_reg    <= scan_d;
                        best_idx_reg <= ridx_reg;
                        best_reg     <= front_q;
                    end
                    if (!rdv_reg && (idx_reg == fcount_reg))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (bestd_reg >= {thr_reg, {FRAC_W{1'b0}}})
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        fcount_reg <= fcount_reg - 1'b1;
                        bp_reg     <= PW'(32'(best_reg.y) * 32'(IMAGE_WIDTH)
                                    + 32'(best_reg.x));
                        prod_reg   <= mean_reg * count_reg;
                        state_reg  <= S_MOVE;
                    end
                end
                S_MOVE:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_quot;
                        count_reg <= count_inc;
                        cx_reg    <= best_reg.x;
                        cy_reg    <= best_reg.y;
                        cur_p_reg <= bp_reg;
                        nb_reg    <= '0;
                        psz_reg   <= REGION_W'(count_inc);
                        state_reg <= (count_inc < N_ALL) ? S_NB : S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        keep_reg      <= pk_reg;
                        size_reg      <= psz_reg;
                        skip_reg      <= pskip_reg;
                        rovf_reg      <= ovf_reg;
                        pend_res_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall         = state_reg != S_IDLE;
    assign cfg_ready         = 1'b1;
    assign res_valid         = res_valid_reg;
    assign keep_bit          = keep_reg;
    assign region_size       = size_reg;
    assign seed_skipped      = skip_reg;
    assign frontier_overflow = rovf_reg;

endmodule

`default_nettype wire

FILE: src/drg_checker.sv
// port-level checks for the depth seeded region growing core
// depends on drg_pkg; bound to the top level below
`default_nettype none

module drg_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           res_valid,
    input wire logic                           res_stall,
    input wire logic                           keep_bit,
    input wire logic [drg_pkg::REGION_W-1:0]   region_size,
    input wire logic                           seed_skipped,
    input wire logic                           frontier_overflow
);

    import drg_pkg::*;

    // a stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(region_size))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && keep_bit |-> region_size == '0 && !seed_skipped && !frontier_overflow)
        else $error("read result carries grow fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seed_skipped |-> region_size == '0 && !frontier_overflow)
        else $error("skipped seed reports a region");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frontier_overflow |-> region_size != '0)
        else $error("overflow without a region");

endmodule

bind depth_seeded_region_growing_core drg_checker u_drg_checker (.*);

`default_nettype wire
